>>> rtl/core/mwq_pkg.sv
`timescale 1ns / 1ps

package mwq_pkg;

  localparam int CELL_COUNT = 256;
  localparam int CELL_W     = $clog2(CELL_COUNT);
  // sides with bit 0 clear live in bank 0, the others in bank 1
  localparam int BANK_DEPTH = CELL_COUNT * 2;
  localparam int BANK_AW    = CELL_W + 1;

  localparam int CNT_W = 4;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [1:0] OBS_NO_WALL = 2'd0;
  localparam logic [1:0] OBS_WALL    = 2'd1;

  typedef logic [2*CNT_W-1:0] entry_t;
  typedef logic [BANK_AW-1:0] bank_addr_t;

  typedef struct packed {
    logic   cur_we;
    logic   nbr_we;
    entry_t cur;
    entry_t nbr;
    logic   commit;
    logic   wall;
  } upd_t;

endpackage

>>> rtl/core/mwq_update.sv
`timescale 1ns / 1ps

module mwq_update (
  input  logic                      active,
  input  logic                      absent,
  input  logic                      has_nbr,
  input  logic [mwq_pkg::CNT_W-1:0] threshold,
  input  mwq_pkg::entry_t           cur_entry,
  input  mwq_pkg::entry_t           nbr_entry,
  output mwq_pkg::upd_t             upd
);
  import mwq_pkg::*;

  logic [CNT_W-1:0] thr;
  logic [CNT_W-1:0] cur_same;
  logic [CNT_W-1:0] cur_opp;
  logic [CNT_W-1:0] nbr_same;
  logic [CNT_W-1:0] cur_inc;
  logic [CNT_W-1:0] nbr_inc;
  logic [CNT_W-1:0] cur_new;
  logic [CNT_W-1:0] nbr_new;
  logic             contra;
  logic             hit;

  // a zero threshold acts as one
  assign thr = (threshold == '0) ? CNT_W'(1) : threshold;

  assign cur_same = absent ? cur_entry[2*CNT_W-1:CNT_W] : cur_entry[CNT_W-1:0];
  assign cur_opp  = absent ? cur_entry[CNT_W-1:0] : cur_entry[2*CNT_W-1:CNT_W];
  assign nbr_same = absent ? nbr_entry[2*CNT_W-1:CNT_W] : nbr_entry[CNT_W-1:0];

  assign contra  = (cur_opp != '0);
  assign cur_inc = (cur_same == CNT_MAX) ? CNT_MAX : cur_same + CNT_W'(1);
  assign nbr_inc = (nbr_same == CNT_MAX) ? CNT_MAX : nbr_same + CNT_W'(1);
  assign hit     = (cur_inc >= thr);
  assign cur_new = hit ? thr : cur_inc;
  assign nbr_new = hit ? thr : nbr_inc;

  always_comb begin
    upd.cur_we = active;
    upd.nbr_we = active && has_nbr;
    if (contra) begin
      upd.cur = '0;
      upd.nbr = '0;
    end else if (absent) begin
      upd.cur = {cur_new, cur_entry[CNT_W-1:0]};
      upd.nbr = {nbr_new, nbr_entry[CNT_W-1:0]};
    end else begin
      upd.cur = {cur_entry[2*CNT_W-1:CNT_W], cur_new};
      upd.nbr = {nbr_entry[2*CNT_W-1:CNT_W], nbr_new};
    end
    upd.commit = active && !contra && hit;
    upd.wall   = active && !contra && hit && !absent;
  end

endmodule

>>> rtl/core/maze_wall_observation_qualifier.sv
`timescale 1ns / 1ps
// an accepted observation is registered into stage s1 with its bank reads, then into the result register
// throughput: one observation per cycle while in_stall is low, set by the single read and write port of each
//   counter bank (the two entries an observation touches always sit in different banks)
// reset: synchronous; afterwards both banks are cleared in one pass over all BANK_DEPTH entries
//   (512 for 256 cells), during which no observation is accepted
module maze_wall_observation_qualifier (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [mwq_pkg::CNT_W-1:0]  cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 cell_req,
  input  logic [1:0]                 side,
  input  logic [1:0]                 observation,
  input  logic                       already_known,
  input  logic [7:0]                 neighbor_cell,
  input  logic                       neighbor_valid,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       commit,
  output logic                       commit_wall
);
  import mwq_pkg::*;

  logic [CNT_W-1:0] detect_threshold;

  logic       clearing;
  bank_addr_t clr_addr;

  logic       in_acc;
  bank_addr_t in_ci_addr;
  bank_addr_t in_ni_addr;
  logic       in_active;
  logic       in_has_nbr;

  logic       s1_valid;
  logic       s1_valid_next;
  logic       s1_adv;
  bank_addr_t s1_ci_addr;
  bank_addr_t s1_ni_addr;
  logic       s1_side0;
  logic       s1_absent;
  logic       s1_active;
  logic       s1_has_nbr;

  logic       res_valid;
  logic       res_valid_next;

  bank_addr_t bank_raddr [2];
  bank_addr_t bank_waddr [2];
  entry_t     bank_wdata [2];
  logic       bank_wen   [2];
  entry_t     rd_data    [2];

  entry_t     cur_entry;
  entry_t     nbr_entry;
  upd_t       upd;

  assign in_acc     = in_valid && !in_stall;
  assign s1_adv     = s1_valid && (!res_valid || !out_stall);
  assign in_stall   = clearing || (s1_valid && !s1_adv);
  assign out_valid  = res_valid;

  assign in_ci_addr = {CELL_W'(cell_req), side[1]};
  // matching side of the neighbour flips bit 0 only, so it lands in the other bank
  assign in_ni_addr = {CELL_W'(neighbor_cell), side[1]};
  assign in_active  = !already_known
                      && (observation == OBS_NO_WALL || observation == OBS_WALL)
                      && (32'(cell_req) < 32'(CELL_COUNT));
  assign in_has_nbr = neighbor_valid && (32'(neighbor_cell) < 32'(CELL_COUNT));

  assign bank_raddr[0] = side[0] ? in_ni_addr : in_ci_addr;
  assign bank_raddr[1] = side[0] ? in_ci_addr : in_ni_addr;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      detect_threshold <= CNT_W'(3);
    end else if (cfg_wr_en) begin
      detect_threshold <= cfg_wr_data;
    end
  end

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + BANK_AW'(1);
      if (clr_addr == BANK_AW'(BANK_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  for (genvar b = 0; b < 2; b++) begin : g_bank
    entry_t mem [BANK_DEPTH];
    entry_t rd_q;
    logic   byp_hit;
    entry_t byp_data;
    logic   own_cur;

    assign own_cur = (s1_side0 == 1'(b));

    always_comb begin
      if (clearing) begin
        bank_wen[b]   = 1'b1;
        bank_waddr[b] = clr_addr;
        bank_wdata[b] = '0;
      end else begin
        bank_wen[b]   = s1_adv && (own_cur ? upd.cur_we : upd.nbr_we);
        bank_waddr[b] = own_cur ? s1_ci_addr : s1_ni_addr;
        bank_wdata[b] = own_cur ? upd.cur : upd.nbr;
      end
    end

    always_ff @(posedge clk) begin
      if (bank_wen[b]) begin
        mem[bank_waddr[b]] <= bank_wdata[b];
      end
    end

    // read on accept; a write to the same entry in that cycle is forwarded
    always_ff @(posedge clk) begin
      if (in_acc) begin
        rd_q     <= mem[bank_raddr[b]];
        byp_hit  <= bank_wen[b] && (bank_waddr[b] == bank_raddr[b]);
        byp_data <= bank_wdata[b];
      end
    end

    assign rd_data[b] = byp_hit ? byp_data : rd_q;
  end

  assign cur_entry = s1_side0 ? rd_data[1] : rd_data[0];
  assign nbr_entry = s1_side0 ? rd_data[0] : rd_data[1];

  mwq_update u_update (
    .active    (s1_active),
    .absent    (s1_absent),
    .has_nbr   (s1_has_nbr),
    .threshold (detect_threshold),
    .cur_entry (cur_entry),
    .nbr_entry (nbr_entry),
    .upd       (upd)
  );

  always_comb begin
    s1_valid_next = s1_valid;
    if (in_acc) begin
      s1_valid_next = 1'b1;
    end else if (s1_adv) begin
      s1_valid_next = 1'b0;
    end
  end

  always_comb begin
    res_valid_next = res_valid;
    if (s1_adv) begin
      res_valid_next = 1'b1;
    end else if (res_valid && !out_stall) begin
      res_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      s1_valid  <= s1_valid_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ci_addr <= in_ci_addr;
      s1_ni_addr <= in_ni_addr;
      s1_side0   <= side[0];
      s1_absent  <= (observation == OBS_NO_WALL);
      s1_active  <= in_active;
      s1_has_nbr <= in_has_nbr;
    end
    if (s1_adv) begin
      commit      <= upd.commit;
      commit_wall <= upd.wall;
    end
  end

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_acc)
    else $error("observation accepted during clearing pass");

  a_pipe_empty_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!s1_valid && !res_valid))
    else $error("pipeline busy during clearing pass");

  a_adv_loads_result: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> res_valid)
    else $error("stage advanced without loading result");

  a_wall_needs_commit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (commit || !commit_wall))
    else $error("commit_wall set without commit");

  a_stage_holds_on_stall: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> s1_valid && $stable(s1_ci_addr))
    else $error("stalled stage lost its transaction");

endmodule
